### design/tali_pkg.sv
// Package for the three-axis line step interpolator.
// Holds the request and result word types, axis codes and axis pairing.
// No dependencies.
package tali_pkg;

    // Width of the target fields on the request channel.
    localparam int IN_WIDTH = 24;
    // Default width of the kept positions.
    localparam int POS_WIDTH_DEF = 24;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic                       req_type;
        logic signed [IN_WIDTH-1:0] target_x;
        logic signed [IN_WIDTH-1:0] target_y;
        logic signed [IN_WIDTH-1:0] target_z;
    } req_word_t;

    // Bit 0 of step and dir is X, bit 1 is Y, bit 2 is Z.
    typedef struct packed {
        logic [2:0] step;
        logic [2:0] dir;
        axis_t      drive;
        logic       done;
    } res_word_t;

    // X drives Y and Z, Y drives X and Z, Z drives Y and X.
    function automatic axis_t second_axis(axis_t a);
        axis_t r;
        case (a)
            AXIS_X:  r = AXIS_Y;
            AXIS_Y:  r = AXIS_X;
            AXIS_Z:  r = AXIS_Y;
            default: r = AXIS_Y;
        endcase
        return r;
    endfunction

    function automatic axis_t third_axis(axis_t a);
        axis_t r;
        case (a)
            AXIS_X:  r = AXIS_Z;
            AXIS_Y:  r = AXIS_Z;
            AXIS_Z:  r = AXIS_X;
            default: r = AXIS_Z;
        endcase
        return r;
    endfunction

endpackage

### design/three_axis_line_step_interpolator.sv
// Top level of the three-axis line step interpolator (3D Bresenham).
// Uses tali_pkg, tali_in_reg, tali_core and tali_out_reg.
//
//   Channel   Ports                                    Moves
//   s_        s_valid/s_ready                          request word: load or tick
//   m_        m_valid/m_ready                          result word: steps, dirs, driving axis, done
//   cfg_      cfg_we/cfg_wdata                         relative_mode write
//
// A request word is taken into the input register, processed against the kept
// state, and its result lands in the output register; one word per cycle
// sustained while m_ready does not stall.
// The rate is set by the registered state update loop (positions, errors).
// A stalled m_ready holds the result and then the input register; no clearing
// pass is needed after reset.
module three_axis_line_step_interpolator #(
    parameter int POS_WIDTH = tali_pkg::POS_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic                                  cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_req_type,
    input  logic signed [tali_pkg::IN_WIDTH-1:0]  s_target_x,
    input  logic signed [tali_pkg::IN_WIDTH-1:0]  s_target_y,
    input  logic signed [tali_pkg::IN_WIDTH-1:0]  s_target_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_step_x,
    output logic                                  m_step_y,
    output logic                                  m_step_z,
    output logic                                  m_dir_x,
    output logic                                  m_dir_y,
    output logic                                  m_dir_z,
    output logic [1:0]                            m_driving_axis,
    output logic                                  m_move_done
);

    tali_pkg::req_word_t s_word, word;
    tali_pkg::res_word_t res, m_word;
    logic                word_valid, can_load, fire;

    assign s_word.req_type = s_req_type;
    assign s_word.target_x = s_target_x;
    assign s_word.target_y = s_target_y;
    assign s_word.target_z = s_target_z;

    assign fire = word_valid && can_load;

    tali_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .word_valid (word_valid),
        .word       (word),
        .take       (fire)
    );

    tali_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .word      (word),
        .res       (res)
    );

    tali_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .res      (res),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word)
    );

    assign m_step_x       = m_word.step[0];
    assign m_step_y       = m_word.step[1];
    assign m_step_z       = m_word.step[2];
    assign m_dir_x        = m_word.dir[0];
    assign m_dir_y        = m_word.dir[1];
    assign m_dir_z        = m_word.dir[2];
    assign m_driving_axis = m_word.drive;
    assign m_move_done    = m_word.done;

endmodule

### design/tali_in_reg.sv
// Input register of the interpolator: holds one request word.
// Depends on tali_pkg for the request word type.
module tali_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tali_pkg::req_word_t s_word,
    output logic                word_valid,
    output tali_pkg::req_word_t word,
    input  logic                take
);

    logic                valid_reg;
    tali_pkg::req_word_t word_reg;

    // A new word may enter in the same cycle the held one is consumed.
    assign s_ready    = !valid_reg || take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

endmodule

### design/tali_core.sv
// Interpolator core: kept positions, error terms and move setup, with the
// combinational load and tick logic. Depends on tali_pkg.
module tali_core #(
    parameter int POS_WIDTH = tali_pkg::POS_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                fire,
    input  tali_pkg::req_word_t word,
    output tali_pkg::res_word_t res
);

    localparam int AW = (POS_WIDTH > tali_pkg::IN_WIDTH) ? POS_WIDTH : tali_pkg::IN_WIDTH;
    localparam int DW = AW + 1;
    localparam int EW = POS_WIDTH + 3;

    logic                        rel_mode_reg;
    logic signed [POS_WIDTH-1:0] pos_reg [3];
    logic signed [POS_WIDTH-1:0] pos_next [3];
    logic [AW-1:0]               abs_reg [3];
    logic [AW-1:0]               abs_next [3];
    logic [2:0]                  neg_reg, neg_next;
    logic [2:0]                  nz_reg, nz_next;
    tali_pkg::axis_t             drive_reg, drive_next;
    logic signed [POS_WIDTH-1:0] target_reg, target_next;
    logic [EW-1:0]               err2_reg, err2_next;
    logic [EW-1:0]               err3_reg, err3_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            rel_mode_reg <= cfg_wdata;
        end
    end

    always_comb begin
        logic signed [tali_pkg::IN_WIDTH-1:0] tin [3];
        logic signed [POS_WIDTH-1:0]          twrap;
        logic signed [DW-1:0]                 d [3];
        logic [AW-1:0]                        ad [3];
        logic [2:0]                           neg_d, nz_d;
        tali_pkg::axis_t                      sel_d, l2, l3, t1, t2, t3;
        logic [EW-1:0]                        twice1, twice2, twice3;
        logic                                 active, s2, s3;
        logic [2:0]                           step_t;
        logic signed [POS_WIDTH-1:0]          pos_t [3];

        tin[0] = word.target_x;
        tin[1] = word.target_y;
        tin[2] = word.target_z;

        // Move setup: deltas, magnitudes and the driving axis.
        for (int i = 0; i < 3; i++) begin
            twrap = POS_WIDTH'(tin[i]);
            if (rel_mode_reg) begin
                d[i] = DW'(tin[i]);
            end else begin
                d[i] = DW'(twrap) - DW'(pos_reg[i]);
            end
            neg_d[i] = d[i][DW-1];
            nz_d[i]  = (d[i] != '0);
            ad[i]    = neg_d[i] ? AW'(-d[i]) : AW'(d[i]);
        end

        if (ad[0] >= ad[1] && ad[0] >= ad[2]) begin
            sel_d = tali_pkg::AXIS_X;
        end else if (ad[1] >= ad[2]) begin
            sel_d = tali_pkg::AXIS_Y;
        end else begin
            sel_d = tali_pkg::AXIS_Z;
        end
        l2 = tali_pkg::second_axis(sel_d);
        l3 = tali_pkg::third_axis(sel_d);

        // Tick: while the move is active the driving axis steps, the others follow their errors.
        t1 = drive_reg;
        t2 = tali_pkg::second_axis(drive_reg);
        t3 = tali_pkg::third_axis(drive_reg);
        twice1 = EW'(abs_reg[t1]) << 1;
        twice2 = EW'(abs_reg[t2]) << 1;
        twice3 = EW'(abs_reg[t3]) << 1;
        active = (pos_reg[t1] != target_reg);
        s2     = !err2_reg[EW-1];
        s3     = !err3_reg[EW-1];
        for (int i = 0; i < 3; i++) begin
            step_t[i] = active && ((2'(i) == t1) || ((2'(i) == t2) && s2 && nz_reg[i])
                                   || ((2'(i) == t3) && s3 && nz_reg[i]));
            if (step_t[i] && nz_reg[i]) begin
                pos_t[i] = neg_reg[i] ? pos_reg[i] - 1'b1 : pos_reg[i] + 1'b1;
            end else begin
                pos_t[i] = pos_reg[i];
            end
        end

        for (int i = 0; i < 3; i++) begin
            pos_next[i] = pos_reg[i];
            abs_next[i] = abs_reg[i];
        end
        neg_next    = neg_reg;
        nz_next     = nz_reg;
        drive_next  = drive_reg;
        target_next = target_reg;
        err2_next   = err2_reg;
        err3_next   = err3_reg;
        res.step    = '0;

        if (word.req_type == tali_pkg::REQ_LOAD) begin
            for (int i = 0; i < 3; i++) begin
                abs_next[i] = ad[i];
            end
            neg_next    = neg_d;
            nz_next     = nz_d;
            drive_next  = sel_d;
            target_next = pos_reg[sel_d] + POS_WIDTH'(d[sel_d]);
            err2_next   = (EW'(ad[l2]) << 1) - EW'(ad[sel_d]);
            err3_next   = (EW'(ad[l3]) << 1) - EW'(ad[sel_d]);
        end else if (active) begin
            for (int i = 0; i < 3; i++) begin
                pos_next[i] = pos_t[i];
            end
            err2_next = err2_reg - (s2 ? twice1 : '0) + twice2;
            err3_next = err3_reg - (s3 ? twice1 : '0) + twice3;
            res.step  = step_t;
        end

        res.dir   = ~neg_next;
        res.drive = drive_next;
        res.done  = (pos_next[drive_next] == target_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                abs_reg[i] <= '0;
            end
            neg_reg    <= '0;
            nz_reg     <= '0;
            drive_reg  <= tali_pkg::AXIS_X;
            target_reg <= '0;
            err2_reg   <= '0;
            err3_reg   <= '0;
        end else if (fire) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= pos_next[i];
                abs_reg[i] <= abs_next[i];
            end
            neg_reg    <= neg_next;
            nz_reg     <= nz_next;
            drive_reg  <= drive_next;
            target_reg <= target_next;
            err2_reg   <= err2_next;
            err3_reg   <= err3_next;
        end
    end

endmodule

### design/tali_out_reg.sv
// Result register of the interpolator: holds one result word until taken.
// Depends on tali_pkg for the result word type.
module tali_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  tali_pkg::res_word_t res,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output tali_pkg::res_word_t m_word
);

    logic                valid_reg;
    tali_pkg::res_word_t res_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_word   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule
